// ===== design/glzw_pkg.sv =====
// glzw_pkg: shared constants and types for the GIF LZW code decoder.
// No dependencies; used by gif_lzw_code_decoder, glzw_checker and the bench.
package glzw_pkg;

  localparam int DICT_ENTRIES  = 4096;
  localparam int MAX_CODE_BITS = 12;
  localparam int STACK_DEPTH   = 4096;
  localparam int DICT_AW       = $clog2(DICT_ENTRIES);
  localparam int STACK_AW      = $clog2(STACK_DEPTH);
  localparam int CODE_W        = 12;
  localparam int NEXT_W        = 13;
  localparam int DEPTH_W       = 13;

  typedef enum logic [1:0] {
    OP_BYTE  = 2'd0,
    OP_TICK  = 2'd1,
    OP_START = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_CODE  = 2'd2,
    ST_AFTER_END = 2'd3
  } status_t;

  typedef struct packed {
    logic [CODE_W-1:0] prefix;
    logic [7:0]        last_char;
    logic [7:0]        first_char;
  } dict_entry_t;

endpackage

// ===== design/glzw_ram.sv =====
// glzw_ram: generic single-write, single-read RAM with registered read data.
// No dependencies; holds the dictionary and the character stack.
module glzw_ram #(
  parameter int DW = 8,
  parameter int AW = 12
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [0:(1<<AW)-1];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/gif_lzw_code_decoder.sv =====
// gif_lzw_code_decoder: variable-width GIF LZW decoder, one result beat per input beat.
// Sequence: byte, start and idle beats, and ticks that clear, end, take a first or bad code or
// find too few bits, load their result from S_IDLE; a tick that pops the stack goes via S_POP;
// a tick that decodes any other code goes via S_PREV, S_WALK (once per entry walked), S_FIN.
// Throughput: one beat in flight; in_ready is high in idle when the output slot is free.
// Reset (synchronous, rst_n low): control state cleared; RAMs are not cleared.
module gif_lzw_code_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_operation,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_pixel_valid,
  output logic [7:0] out_pixel_index,
  output logic       out_want_byte,
  output logic       out_end_of_image,
  output logic [1:0] out_status,
  input  logic       cfg_we,
  input  logic [3:0] cfg_min_code_size
);

  typedef enum logic [2:0] {S_IDLE, S_POP, S_PREV, S_WALK, S_FIN} state_t;

  localparam logic [3:0]                   RST_SIZE = 4'd8;
  localparam logic [glzw_pkg::NEXT_W-1:0]  DICT_END = glzw_pkg::NEXT_W'(glzw_pkg::DICT_ENTRIES);
  localparam logic [glzw_pkg::DEPTH_W-1:0] STK_END  = glzw_pkg::DEPTH_W'(glzw_pkg::STACK_DEPTH);
  localparam logic [glzw_pkg::NEXT_W-1:0]  RST_NEXT =
    (glzw_pkg::NEXT_W'(1) << RST_SIZE) + glzw_pkg::NEXT_W'(2);

  function automatic logic [3:0] eff_size(input logic [3:0] s);
    logic [3:0] r;
    r = s;
    if (s < 4'd2) r = 4'd2;
    if (s > 4'd8) r = 4'd8;
    return r;
  endfunction

  state_t                          state_r, state_nxt;
  logic [3:0]                      min_size_r, width_r, width_nxt;
  logic [23:0]                     buf_r, buf_nxt;
  logic [4:0]                      bits_r, bits_nxt;
  logic [glzw_pkg::DEPTH_W-1:0]    depth_r, depth_nxt;
  logic [glzw_pkg::NEXT_W-1:0]     next_r, next_nxt;
  logic [glzw_pkg::CODE_W-1:0]     prev_r, prev_nxt, code_r, code_nxt, c_r, c_nxt;
  logic                            have_prev_r, have_prev_nxt, ended_r, ended_nxt;
  logic                            kwk_r, kwk_nxt, cap_fc_r, cap_fc_nxt;
  logic [7:0]                      fc_r, fc_nxt, pf_r, pf_nxt, top_r, top_nxt;

  logic                            out_valid_r, out_pv_r, out_want_r, out_end_r;
  logic [7:0]                      out_pix_r;
  logic [1:0]                      out_st_r;
  logic                            load_out, o_pv;
  logic [7:0]                      o_pix;
  glzw_pkg::status_t               o_st;

  logic                            dict_we;
  logic [glzw_pkg::DICT_AW-1:0]    dict_waddr, dict_raddr;
  glzw_pkg::dict_entry_t           dict_wdata, dict_rdata;
  logic                            stk_we;
  logic [glzw_pkg::STACK_AW-1:0]   stk_waddr, stk_raddr;
  logic [7:0]                      stk_wdata, stk_rdata;

  logic                            out_free, in_fire;
  logic [3:0]                      eff;
  logic [glzw_pkg::NEXT_W-1:0]     roots, code_x, prev_x, c_start_x, c_new_x, next_inc;
  logic [glzw_pkg::CODE_W-1:0]     code_mask, code_cur, c_start;
  logic [glzw_pkg::DEPTH_W-1:0]    depth_after;
  logic [7:0]                      pf_cur;

  glzw_ram #(.DW($bits(glzw_pkg::dict_entry_t)), .AW(glzw_pkg::DICT_AW)) u_dict (
    .clk   (clk),
    .we    (dict_we),
    .waddr (dict_waddr),
    .wdata (dict_wdata),
    .raddr (dict_raddr),
    .rdata (dict_rdata)
  );

  glzw_ram #(.DW(8), .AW(glzw_pkg::STACK_AW)) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) && out_free;
  assign in_fire   = in_valid && in_ready;
  assign eff       = eff_size(min_size_r);
  assign roots     = glzw_pkg::NEXT_W'(1) << eff;
  assign code_mask = glzw_pkg::CODE_W'((13'd1 << width_r) - 13'd1);
  assign code_cur  = buf_r[glzw_pkg::CODE_W-1:0] & code_mask;
  assign code_x    = glzw_pkg::NEXT_W'(code_cur);
  assign prev_x    = glzw_pkg::NEXT_W'(prev_r);
  assign next_inc  = next_r + glzw_pkg::NEXT_W'(1);

  always_comb begin
    state_nxt     = state_r;
    width_nxt     = width_r;
    buf_nxt       = buf_r;
    bits_nxt      = bits_r;
    depth_nxt     = depth_r;
    next_nxt      = next_r;
    prev_nxt      = prev_r;
    code_nxt      = code_r;
    c_nxt         = c_r;
    have_prev_nxt = have_prev_r;
    ended_nxt     = ended_r;
    kwk_nxt       = kwk_r;
    cap_fc_nxt    = cap_fc_r;
    fc_nxt        = fc_r;
    pf_nxt        = pf_r;
    top_nxt       = top_r;
    load_out      = 1'b0;
    o_pv          = 1'b0;
    o_pix         = 8'd0;
    o_st          = glzw_pkg::ST_OK;
    dict_we       = 1'b0;
    dict_waddr    = next_r[glzw_pkg::DICT_AW-1:0];
    dict_wdata    = '{prefix: prev_r, last_char: fc_r, first_char: pf_r};
    dict_raddr    = prev_r[glzw_pkg::DICT_AW-1:0];
    stk_we        = 1'b0;
    stk_waddr     = depth_r[glzw_pkg::STACK_AW-1:0];
    stk_wdata     = 8'd0;
    stk_raddr     = depth_r[glzw_pkg::STACK_AW-1:0];
    pf_cur        = 8'd0;
    c_start       = code_r;
    c_start_x     = '0;
    c_new_x       = '0;
    depth_after   = depth_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (glzw_pkg::op_t'(in_operation))
            glzw_pkg::OP_BYTE: begin
              load_out = 1'b1;
              if (ended_r) begin
                o_st = glzw_pkg::ST_AFTER_END;
              end else if (bits_r > 5'd16) begin
                o_st = glzw_pkg::ST_FULL;
              end else begin
                buf_nxt  = buf_r | (24'(in_data_byte) << bits_r);
                bits_nxt = bits_r + 5'd8;
              end
            end
            glzw_pkg::OP_TICK: begin
              if (depth_r != '0) begin
                depth_nxt = depth_r - glzw_pkg::DEPTH_W'(1);
                stk_raddr = depth_nxt[glzw_pkg::STACK_AW-1:0];
                state_nxt = S_POP;
              end else if (ended_r) begin
                load_out = 1'b1;
                o_st     = glzw_pkg::ST_AFTER_END;
              end else if (bits_r < 5'(width_r)) begin
                load_out = 1'b1;
              end else begin
                buf_nxt  = buf_r >> width_r;
                bits_nxt = bits_r - 5'(width_r);
                code_nxt = code_cur;
                if (code_x == roots) begin
                  load_out      = 1'b1;
                  next_nxt      = roots + glzw_pkg::NEXT_W'(2);
                  width_nxt     = eff + 4'd1;
                  have_prev_nxt = 1'b0;
                end else if (code_x == roots + glzw_pkg::NEXT_W'(1)) begin
                  load_out  = 1'b1;
                  ended_nxt = 1'b1;
                end else if (!have_prev_r) begin
                  load_out = 1'b1;
                  if (code_x >= roots) begin
                    o_st = glzw_pkg::ST_BAD_CODE;
                  end else begin
                    o_pv          = 1'b1;
                    o_pix         = code_cur[7:0];
                    prev_nxt      = code_cur;
                    have_prev_nxt = 1'b1;
                  end
                end else if (code_x < next_r || (code_x == next_r && next_r < DICT_END)) begin
                  kwk_nxt   = (code_x == next_r);
                  state_nxt = S_PREV;
                end else begin
                  load_out = 1'b1;
                  o_st     = glzw_pkg::ST_BAD_CODE;
                end
              end
            end
            glzw_pkg::OP_START: begin
              load_out      = 1'b1;
              next_nxt      = roots + glzw_pkg::NEXT_W'(2);
              width_nxt     = eff + 4'd1;
              have_prev_nxt = 1'b0;
              depth_nxt     = '0;
              prev_nxt      = '0;
              buf_nxt       = '0;
              bits_nxt      = '0;
              ended_nxt     = 1'b0;
            end
            default: begin
              load_out = 1'b1;
            end
          endcase
        end
      end
      S_POP: begin
        load_out  = 1'b1;
        o_pv      = 1'b1;
        o_pix     = stk_rdata;
        state_nxt = S_IDLE;
      end
      S_PREV: begin
        // dictionary data for previous_code is on the read port
        if (prev_x < roots || prev_x >= DICT_END) begin
          pf_cur = prev_r[7:0];
        end else begin
          pf_cur = dict_rdata.first_char;
        end
        pf_nxt = pf_cur;
        if (kwk_r) begin
          fc_nxt      = pf_cur;
          stk_we      = 1'b1;
          stk_wdata   = pf_cur;
          top_nxt     = pf_cur;
          depth_after = depth_r + glzw_pkg::DEPTH_W'(1);
          c_start     = prev_r;
          cap_fc_nxt  = 1'b0;
        end else begin
          fc_nxt      = code_r[7:0];
          c_start     = code_r;
          cap_fc_nxt  = 1'b1;
        end
        depth_nxt = depth_after;
        c_nxt     = c_start;
        c_start_x = glzw_pkg::NEXT_W'(c_start);
        if (c_start_x >= roots + glzw_pkg::NEXT_W'(2) && c_start_x < DICT_END &&
            depth_after < STK_END) begin
          dict_raddr = c_start[glzw_pkg::DICT_AW-1:0];
          state_nxt  = S_WALK;
        end else begin
          state_nxt  = S_FIN;
        end
      end
      S_WALK: begin
        if (cap_fc_r) begin
          fc_nxt     = dict_rdata.first_char;
          cap_fc_nxt = 1'b0;
        end
        stk_we      = 1'b1;
        stk_wdata   = dict_rdata.last_char;
        top_nxt     = dict_rdata.last_char;
        depth_after = depth_r + glzw_pkg::DEPTH_W'(1);
        depth_nxt   = depth_after;
        c_nxt       = dict_rdata.prefix;
        c_new_x     = glzw_pkg::NEXT_W'(dict_rdata.prefix);
        if (c_new_x >= roots + glzw_pkg::NEXT_W'(2) && c_new_x < DICT_END &&
            depth_after < STK_END) begin
          dict_raddr = dict_rdata.prefix[glzw_pkg::DICT_AW-1:0];
        end else begin
          state_nxt  = S_FIN;
        end
      end
      S_FIN: begin
        // final push of the root char and the pop of the top cancel out
        load_out = 1'b1;
        o_pv     = 1'b1;
        if (depth_r < STK_END) begin
          o_pix = c_r[7:0];
        end else begin
          o_pix     = top_r;
          depth_nxt = depth_r - glzw_pkg::DEPTH_W'(1);
        end
        if (next_r < DICT_END) begin
          dict_we  = 1'b1;
          next_nxt = next_inc;
          if (14'(next_inc) >= (14'd1 << width_r) &&
              width_r < 4'(glzw_pkg::MAX_CODE_BITS)) begin
            width_nxt = width_r + 4'd1;
          end
        end
        prev_nxt  = code_r;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      min_size_r  <= RST_SIZE;
      width_r     <= RST_SIZE + 4'd1;
      buf_r       <= '0;
      bits_r      <= '0;
      depth_r     <= '0;
      next_r      <= RST_NEXT;
      prev_r      <= '0;
      have_prev_r <= 1'b0;
      ended_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      width_r     <= width_nxt;
      buf_r       <= buf_nxt;
      bits_r      <= bits_nxt;
      depth_r     <= depth_nxt;
      next_r      <= next_nxt;
      prev_r      <= prev_nxt;
      have_prev_r <= have_prev_nxt;
      ended_r     <= ended_nxt;
      if (cfg_we) begin
        min_size_r <= cfg_min_code_size;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    code_r   <= code_nxt;
    c_r      <= c_nxt;
    kwk_r    <= kwk_nxt;
    cap_fc_r <= cap_fc_nxt;
    fc_r     <= fc_nxt;
    pf_r     <= pf_nxt;
    top_r    <= top_nxt;
    if (load_out) begin
      out_pv_r   <= o_pv;
      out_pix_r  <= o_pix;
      out_st_r   <= o_st;
      out_want_r <= (bits_nxt <= 5'd16);
      out_end_r  <= ended_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_valid  = out_pv_r;
  assign out_pixel_index  = out_pix_r;
  assign out_want_byte    = out_want_r;
  assign out_end_of_image = out_end_r;
  assign out_status       = out_st_r;

endmodule

// ===== design/glzw_checker.sv =====
// glzw_checker: port-level assertions for gif_lzw_code_decoder, bound to the top level.
// Depends on glzw_pkg.
module glzw_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] in_operation,
  input logic [7:0] in_data_byte,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_pixel_valid,
  input logic [7:0] out_pixel_index,
  input logic       out_want_byte,
  input logic       out_end_of_image,
  input logic [1:0] out_status,
  input logic       cfg_we,
  input logic [3:0] cfg_min_code_size
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel_index) &&
      $stable(out_status) && $stable(out_pixel_valid))
    else $error("result beat changed while stalled");

  a_idle_pixel_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_pixel_valid |-> out_pixel_index == 8'd0)
    else $error("pixel index not zero without a pixel");

  a_pixel_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pixel_valid |-> out_status == 2'(glzw_pkg::ST_OK))
    else $error("pixel with non-ok status");

  a_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == 2'(glzw_pkg::ST_AFTER_END) |-> out_end_of_image)
    else $error("after-end status without end of image");

  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == 2'(glzw_pkg::ST_FULL) |-> !out_want_byte)
    else $error("buffer-full status while asking for bytes");

endmodule

bind gif_lzw_code_decoder glzw_checker u_glzw_checker (.*);

// ===== bench/gif_lzw_code_decoder_test.sv =====
// Self-checking bench for gif_lzw_code_decoder: drives packed LZW code streams and ticks,
// predicts every result beat with a cycle-free LZW decoder model and compares field by field.
// Depends on glzw_pkg and gif_lzw_code_decoder from design/.
module gif_lzw_code_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT  = 20000;
  localparam int HOLD_CYCLES  = 400;
  localparam int RANDOM_BEATS = 300;

  typedef struct packed {
    logic       pixel_valid;
    logic [7:0] pixel_index;
    logic       want_byte;
    logic       end_of_image;
    logic [1:0] status;
  } pixel_beat_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  glzw_pkg::op_t   in_operation = glzw_pkg::OP_NONE;
  logic [7:0]      in_data_byte = 8'h00;
  logic            out_valid;
  logic            out_ready = 1'b0;
  logic            out_pixel_valid;
  logic [7:0]      out_pixel_index;
  logic            out_want_byte;
  logic            out_end_of_image;
  logic [1:0]      out_status;
  logic            cfg_we = 1'b0;
  logic [3:0]      cfg_min_code_size = 4'd8;

  gif_lzw_code_decoder DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_data_byte      (in_data_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_pixel_valid   (out_pixel_valid),
    .out_pixel_index   (out_pixel_index),
    .out_want_byte     (out_want_byte),
    .out_end_of_image  (out_end_of_image),
    .out_status        (out_status),
    .cfg_we            (cfg_we),
    .cfg_min_code_size (cfg_min_code_size)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // decoder prediction state
  logic [11:0] dict_prefix [glzw_pkg::DICT_ENTRIES];
  logic [7:0]  dict_last [glzw_pkg::DICT_ENTRIES];
  logic [7:0]  dict_first [glzw_pkg::DICT_ENTRIES];
  logic [7:0]  pix_stack [glzw_pkg::STACK_DEPTH];
  int unsigned stk_depth, nxt_code, cw, prev_code, nbits;
  bit          have_prev, img_ended;
  logic [23:0] bitbuf;
  logic [3:0]  size_reg;

  pixel_beat_t decoded_due[$];
  int unsigned beats_sent = 0;
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  bit          calm = 1'b0;
  bit          hold_req = 1'b0;
  bit          hold_ack = 1'b0;
  int unsigned hold_left = 0;

  // code stream generator state
  int unsigned gen_roots, gen_next, gen_width;
  bit          gen_hp;
  logic [31:0] gen_acc;
  int unsigned gen_acc_bits;
  logic [7:0]  stream_q[$];

  function automatic int unsigned eff_size();
    if (size_reg < 4'd2) return 2;
    if (size_reg > 4'd8) return 8;
    return 32'(size_reg);
  endfunction

  function automatic void restart_dict();
    nxt_code  = (1 << eff_size()) + 2;
    cw        = eff_size() + 1;
    have_prev = 1'b0;
  endfunction

  function automatic void begin_image();
    restart_dict();
    stk_depth = 0;
    prev_code = 0;
    bitbuf    = '0;
    nbits     = 0;
    img_ended = 1'b0;
  endfunction

  function automatic void push_pixel(int unsigned ch);
    if (stk_depth < glzw_pkg::STACK_DEPTH) begin
      pix_stack[stk_depth] = ch[7:0];
      stk_depth++;
    end
  endfunction

  function automatic logic [7:0] lead_char(int unsigned c, int unsigned roots);
    if (c < roots || c >= glzw_pkg::DICT_ENTRIES) return c[7:0];
    return dict_first[c];
  endfunction

  // first char of the string ends on top of the stack
  function automatic void unwind(int unsigned c, int unsigned roots);
    int unsigned steps = 0;
    while (c >= roots + 2 && c < glzw_pkg::DICT_ENTRIES && steps < glzw_pkg::DICT_ENTRIES &&
           stk_depth < glzw_pkg::STACK_DEPTH) begin
      push_pixel(32'(dict_last[c]));
      c = 32'(dict_prefix[c]);
      steps++;
    end
    push_pixel(c);
  endfunction

  function automatic logic [1:0] decode_code();
    int unsigned roots, code, fc;
    roots  = 1 << eff_size();
    code   = 32'(bitbuf & ((24'd1 << cw) - 24'd1));
    bitbuf = bitbuf >> cw;
    nbits -= cw;
    if (code == roots) begin
      restart_dict();
      return glzw_pkg::ST_OK;
    end
    if (code == roots + 1) begin
      img_ended = 1'b1;
      return glzw_pkg::ST_OK;
    end
    if (!have_prev) begin
      if (code >= roots) return glzw_pkg::ST_BAD_CODE;
      push_pixel(code);
      prev_code = code;
      have_prev = 1'b1;
      return glzw_pkg::ST_OK;
    end
    if (code < nxt_code) begin
      fc = 32'(lead_char(code, roots));
      unwind(code, roots);
    end else if (code == nxt_code && nxt_code < glzw_pkg::DICT_ENTRIES) begin
      fc = 32'(lead_char(prev_code, roots));
      push_pixel(fc);
      unwind(prev_code, roots);
    end else begin
      return glzw_pkg::ST_BAD_CODE;
    end
    if (nxt_code < glzw_pkg::DICT_ENTRIES) begin
      dict_prefix[nxt_code] = prev_code[11:0];
      dict_last[nxt_code]   = fc[7:0];
      dict_first[nxt_code]  = lead_char(prev_code, roots);
      nxt_code++;
      if (nxt_code >= (1 << cw) && cw < glzw_pkg::MAX_CODE_BITS) cw++;
    end
    prev_code = code & 32'hFFF;
    return glzw_pkg::ST_OK;
  endfunction

  function automatic pixel_beat_t decode_beat(glzw_pkg::op_t op, logic [7:0] b);
    pixel_beat_t r;
    logic [1:0]  st;
    r  = '0;
    st = glzw_pkg::ST_OK;
    case (op)
      glzw_pkg::OP_BYTE: begin
        if (img_ended) st = glzw_pkg::ST_AFTER_END;
        else if (nbits > 16) st = glzw_pkg::ST_FULL;
        else begin
          bitbuf = bitbuf | (24'(b) << nbits);
          nbits += 8;
        end
      end
      glzw_pkg::OP_TICK: begin
        if (stk_depth == 0) begin
          if (img_ended) st = glzw_pkg::ST_AFTER_END;
          else if (nbits >= cw) st = decode_code();
        end
        if (stk_depth > 0) begin
          stk_depth--;
          r.pixel_valid = 1'b1;
          r.pixel_index = pix_stack[stk_depth];
        end
      end
      glzw_pkg::OP_START: begin_image();
      default: ;
    endcase
    r.want_byte    = nbits <= 16;
    r.end_of_image = img_ended;
    r.status       = st;
    return r;
  endfunction

  function automatic void code_gen_reset();
    gen_roots    = 1 << eff_size();
    gen_next     = gen_roots + 2;
    gen_width    = eff_size() + 1;
    gen_hp       = 1'b0;
    gen_acc      = '0;
    gen_acc_bits = 0;
    stream_q.delete();
  endfunction

  // pack at the current width, then track the width the decoder will use next
  function automatic void code_gen_put(int unsigned code);
    gen_acc = gen_acc | (32'(code) << gen_acc_bits);
    gen_acc_bits += gen_width;
    while (gen_acc_bits >= 8) begin
      stream_q.push_back(gen_acc[7:0]);
      gen_acc = gen_acc >> 8;
      gen_acc_bits -= 8;
    end
    if (code == gen_roots) begin
      gen_next  = gen_roots + 2;
      gen_width = eff_size() + 1;
      gen_hp    = 1'b0;
    end else if (code == gen_roots + 1) begin
    end else if (!gen_hp) begin
      if (code < gen_roots) gen_hp = 1'b1;
    end else if (code <= gen_next && gen_next < glzw_pkg::DICT_ENTRIES) begin
      gen_next++;
      if (gen_next >= (1 << gen_width) && gen_width < glzw_pkg::MAX_CODE_BITS) gen_width++;
    end
  endfunction

  function automatic int unsigned pick_code(int unsigned root_pct, bit tidy);
    int unsigned r, top;
    r   = $urandom_range(0, 99);
    top = (1 << gen_width) - 1;
    if (!gen_hp) begin
      if (!tidy && r < 8) return $urandom_range(gen_roots + 2, top);
      return $urandom_range(0, gen_roots - 1);
    end
    if (r < root_pct) return $urandom_range(0, gen_roots - 1);
    if (!tidy && r >= 97) return gen_roots;
    if (!tidy && r >= 94 && gen_next < top) return $urandom_range(gen_next + 1, top);
    if (r >= 86 && gen_next < glzw_pkg::DICT_ENTRIES) return gen_next;
    if (gen_next > gen_roots + 2) return $urandom_range(gen_roots + 2, gen_next - 1);
    return $urandom_range(0, gen_roots - 1);
  endfunction

  function automatic void build_image(int unsigned n_codes, int unsigned root_pct, bit tidy,
                                      bit lead_clear, bit tail_end, bit fill);
    code_gen_reset();
    if (lead_clear) code_gen_put(gen_roots);
    for (int unsigned i = 0; i < n_codes || (fill && gen_next < glzw_pkg::DICT_ENTRIES); i++)
      code_gen_put(pick_code(root_pct, tidy));
    if (tail_end) code_gen_put(gen_roots + 1);
    if (gen_acc_bits != 0) stream_q.push_back(gen_acc[7:0]);
  endfunction

  function automatic void field_check(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (decoded_due.size() == 0) begin
        $display("%0t ns: unexpected result beat, expected none, actual pixel %0d status %0d",
                 $time, out_pixel_index, out_status);
        mismatches++;
      end else begin
        field_check("pixel_valid", 8'(decoded_due[0].pixel_valid), 8'(out_pixel_valid));
        field_check("pixel_index", decoded_due[0].pixel_index, out_pixel_index);
        field_check("want_byte", 8'(decoded_due[0].want_byte), 8'(out_want_byte));
        field_check("end_of_image", 8'(decoded_due[0].end_of_image), 8'(out_end_of_image));
        field_check("status", 8'(decoded_due[0].status), 8'(out_status));
        void'(decoded_due.pop_front());
      end
    end
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready = 1'b0;
      hold_left--;
    end else if (hold_req != hold_ack) begin
      hold_ack  = hold_req;
      hold_left = HOLD_CYCLES;
      out_ready = 1'b0;
    end else begin
      out_ready = calm || ($urandom_range(0, 99) >= 8);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t ns: no beat moved for %0d cycles", $time, STALL_LIMIT);
        $display("gif_lzw_code_decoder verification failed");
        $finish;
      end
    end
  end

  task automatic send_beat(input glzw_pkg::op_t op, input logic [7:0] b);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 8) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid     = 1'b1;
    in_operation = op;
    in_data_byte = b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    decoded_due.push_back(decode_beat(op, b));
    beats_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (decoded_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_code_size(input logic [3:0] v);
    wait_drained();
    @(negedge clk);
    cfg_we            = 1'b1;
    cfg_min_code_size = v;
    @(posedge clk);
    size_reg = v;
    @(negedge clk);
    cfg_we = 1'b0;
    send_beat(glzw_pkg::OP_START, 8'h00);
  endtask

  task automatic feed_stream(input bit noisy);
    int unsigned r;
    bit          busy;
    while (!img_ended && (stream_q.size() != 0 || stk_depth != 0 || nbits >= cw)) begin
      r    = noisy ? $urandom_range(0, 199) : 200;
      busy = stk_depth != 0 || nbits >= cw;
      if (r == 0) begin
        send_beat(glzw_pkg::OP_START, 8'h00);
        stream_q.delete();
      end else if (r < 5) send_beat(glzw_pkg::OP_NONE, 8'($urandom));
      else if (r < 9 && nbits > 16) send_beat(glzw_pkg::OP_BYTE, 8'($urandom));
      else if (stream_q.size() != 0 && nbits <= 16 && (!busy || $urandom_range(0, 1)))
        send_beat(glzw_pkg::OP_BYTE, stream_q.pop_front());
      else send_beat(glzw_pkg::OP_TICK, 8'($urandom));
    end
    if (!img_ended) send_beat(glzw_pkg::OP_TICK, 8'h00);
    else if (!noisy || $urandom_range(0, 1)) begin
      send_beat(glzw_pkg::OP_BYTE, 8'hA5);
      send_beat(glzw_pkg::OP_TICK, 8'h00);
    end
  endtask

  // reset size, full buffer drop, empty tick, unknown op
  task automatic test_basic_ops();
    send_beat(glzw_pkg::OP_NONE, 8'hFF);
    send_beat(glzw_pkg::OP_TICK, 8'h00);
    send_beat(glzw_pkg::OP_BYTE, 8'h00);
    send_beat(glzw_pkg::OP_BYTE, 8'hFF);
    send_beat(glzw_pkg::OP_BYTE, 8'h80);
    send_beat(glzw_pkg::OP_BYTE, 8'h7F);
    repeat (3) send_beat(glzw_pkg::OP_TICK, 8'h00);
    send_beat(glzw_pkg::OP_START, 8'h00);
  endtask

  // clear, bad first code, KwKwK, code past next, width step, end, input after end
  task automatic test_special_codes();
    set_code_size(4'd2);
    code_gen_reset();
    code_gen_put(gen_roots);
    code_gen_put(gen_roots + 2);
    code_gen_put(1);
    code_gen_put(gen_next);
    code_gen_put(gen_roots + 2);
    code_gen_put(gen_next + 5);
    code_gen_put(gen_roots + 3);
    code_gen_put(3);
    code_gen_put(gen_roots);
    code_gen_put(2);
    code_gen_put(gen_roots + 1);
    if (gen_acc_bits != 0) stream_q.push_back(gen_acc[7:0]);
    feed_stream(1'b0);
    send_beat(glzw_pkg::OP_NONE, 8'h00);
  endtask

  task automatic test_backpressure();
    set_code_size(4'd5);
    build_image(40, 40, 1'b1, 1'b1, 1'b1, 1'b0);
    calm     = 1'b1;
    hold_req = !hold_req;
    feed_stream(1'b0);
    wait_drained();
    calm = 1'b0;
  endtask

  // long image, code width steps from 3 up to 7 bits
  task automatic test_width_growth();
    set_code_size(4'd2);
    build_image(120, 75, 1'b1, 1'b1, 1'b1, 1'b0);
    feed_stream(1'b0);
  endtask

  task automatic test_random_images();
    logic [3:0]  sizes[$] = '{4'd0, 4'd15, 4'd2, 4'd8, 4'd1, 4'd9};
    int unsigned first_beat;
    int unsigned img;
    first_beat = beats_sent;
    img        = 0;
    while (beats_sent - first_beat < RANDOM_BEATS) begin
      set_code_size(img < sizes.size() ? sizes[img] : 4'($urandom_range(0, 15)));
      calm = (img == 3);
      if (img % 7 == 5) begin
        code_gen_reset();
        repeat ($urandom_range(10, 60)) stream_q.push_back(8'($urandom));
      end else begin
        build_image($urandom_range(10, 80), $urandom_range(20, 60), 1'b0,
                    $urandom_range(0, 3) != 0, $urandom_range(0, 4) != 0, 1'b0);
      end
      feed_stream(1'b1);
      img++;
    end
    calm = 1'b0;
  endtask

  initial begin
    size_reg = 4'd8;
    begin_image();
    repeat (4) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;
    test_basic_ops();
    test_special_codes();
    test_backpressure();
    test_width_growth();
    test_random_images();
    wait_drained();
    if (mismatches == 0) $display("gif_lzw_code_decoder verification clean");
    else $display("gif_lzw_code_decoder verification failed");
    $finish;
  end

endmodule
